// ===== hw/rtl/dfe_pkg.sv =====
// ----------------------------------------------------------------------------
// dfe_pkg: shared types and constants of the delimited field extractor
// Register indexes, outcome and phase codes, defaults, and the structs that
// travel between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfe_pkg;

   // Default sizing of the block
   localparam int CAPTURE_DEPTH_DEFAULT     = 64;
   localparam int MAX_PATTERN_BYTES_DEFAULT = 8;
   localparam int CMD_QUEUE_DEPTH           = 2;

   // Fixed field widths
   localparam int BYTE_W        = 8;
   localparam int PATTERN_W     = 64;
   localparam int LENGTH_W      = 4;
   localparam int OCC_W         = 16;
   localparam int CAPT_COUNT_W  = 8;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int OUTCOME_W     = 2;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_PATTERN = 3'd0,
      CSR_START_LENGTH  = 3'd1,
      CSR_END_PATTERN   = 3'd2,
      CSR_END_LENGTH    = 3'd3,
      CSR_OCCURRENCE    = 3'd4
   } csr_index_type;

   // Outcome codes carried on every result of a run
   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_FOUND     = 2'd0,
      OUTCOME_NOT_FOUND = 2'd1,
      OUTCOME_TRUNCATED = 2'd2
   } outcome_type;

   // Per-source scan phase
   typedef enum logic [1:0] {
      PH_SEARCH  = 2'd0,
      PH_CAPTURE = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   // Control part of a run command (the byte count travels beside it)
   typedef struct packed {
      logic        bank;
      outcome_type outcome;
   } cmd_ctl_type;

   // Back end hands a capture bank back to the front end
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   // Effective delimiter length: 0 acts as 1, anything above max acts as max
   function automatic logic [LENGTH_W-1:0] eff_len(input logic [LENGTH_W-1:0] len,
                                                   input int unsigned max_bytes);
      logic [LENGTH_W-1:0] max_len;
      max_len = LENGTH_W'(max_bytes);
      if (len == '0) begin
         return LENGTH_W'(1);
      end else if (len > max_len) begin
         return max_len;
      end
      return len;
   endfunction

endpackage

// ===== hw/rtl/dfe_ram.sv =====
// ----------------------------------------------------------------------------
// dfe_ram: generic simple dual-port RAM
// One write port, one read port with registered read data. Read data holds
// while the read enable is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dfe_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// dfe_cmd_queue: short command FIFO between front end and back end
// Holds run commands so the front end keeps scanning while the back end
// streams out an earlier payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfe_cmd_queue #(
   parameter int WIDTH = 10,
   parameter int DEPTH = dfe_pkg::CMD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = COUNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = COUNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == COUNT_W'(DEPTH));

   // Occupancy must stay consistent with the traffic
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("command queue popped while empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff != COUNT_W'(DEPTH)))
      else $error("command queue pushed while full");

endmodule

// ===== hw/rtl/dfe_front.sv =====
// ----------------------------------------------------------------------------
// dfe_front: scan front end of the delimited field extractor
// Holds the configuration registers, slides the delimiter window, counts
// start matches, writes captured bytes into the capture RAM and issues one
// run command per closed field or per source end without a field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfe_front #(
   parameter int CAPTURE_DEPTH     = dfe_pkg::CAPTURE_DEPTH_DEFAULT,
   parameter int MAX_PATTERN_BYTES = dfe_pkg::MAX_PATTERN_BYTES_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // configuration writes
   input  logic                                      csr_write,
   input  logic [dfe_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [dfe_pkg::CSR_DATA_W-1:0]            csr_data,
   // text input
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [dfe_pkg::BYTE_W-1:0]                req_text_byte,
   input  logic                                      req_source_end,
   // command queue
   input  logic                                      q_full,
   output logic                                      cmd_push,
   output dfe_pkg::cmd_ctl_type                      cmd_ctl,
   output logic [$clog2(CAPTURE_DEPTH+1)-1:0]        cmd_count,
   // bank hand-back from the back end
   input  dfe_pkg::release_type                      release_in,
   // capture RAM write port
   output logic                                      ram_wr_en,
   output logic [$clog2(CAPTURE_DEPTH):0]            ram_wr_addr,
   output logic [dfe_pkg::BYTE_W-1:0]                ram_wr_data
);

   localparam int WIN_W  = dfe_pkg::BYTE_W * MAX_PATTERN_BYTES;
   localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int IDX_W  = $clog2(CAPTURE_DEPTH);
   localparam int CNT_W  = $clog2(CAPTURE_DEPTH + 1);
   localparam int LEN_W  = dfe_pkg::LENGTH_W;
   localparam int OCC_W  = dfe_pkg::OCC_W;
   localparam int CAP_W  = dfe_pkg::CAPT_COUNT_W;

   // Configuration registers
   logic [dfe_pkg::PATTERN_W-1:0] start_pattern_ff;
   logic [LEN_W-1:0]              start_length_ff;
   logic [dfe_pkg::PATTERN_W-1:0] end_pattern_ff;
   logic [LEN_W-1:0]              end_length_ff;
   logic [OCC_W-1:0]              occurrence_ff;

   // Scan state
   logic [WIN_W-1:0]       window_ff, window_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [OCC_W-1:0]       match_count_ff, match_count_in;
   dfe_pkg::phase_type     phase_ff, phase_in;
   logic [CAP_W-1:0]       captured_ff, captured_in;
   logic                   bank_ff, bank_in;
   logic [1:0]             busy_ff, busy_in;

   // Step values for the byte on the input
   logic                   req_accept;
   logic [WIN_W-1:0]       win_step;
   logic [FILL_W-1:0]      fill_step;
   logic [OCC_W-1:0]       mc_step;
   logic [CAP_W-1:0]       cap_step;
   logic [LEN_W-1:0]       start_len;
   logic [LEN_W-1:0]       end_len;
   logic                   start_seen;
   logic                   end_seen;
   logic                   start_hit;
   logic                   open_field;
   logic                   close_field;
   logic [CAP_W-1:0]       payload;
   logic                   truncated;
   logic [CNT_W-1:0]       run_count;

   // Configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         start_pattern_ff <= '0;
         start_length_ff  <= LEN_W'(1);
         end_pattern_ff   <= '0;
         end_length_ff    <= LEN_W'(1);
         occurrence_ff    <= OCC_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            dfe_pkg::CSR_START_PATTERN: start_pattern_ff <= csr_data;
            dfe_pkg::CSR_START_LENGTH:  start_length_ff  <= csr_data[LEN_W-1:0];
            dfe_pkg::CSR_END_PATTERN:   end_pattern_ff   <= csr_data;
            dfe_pkg::CSR_END_LENGTH:    end_length_ff    <= csr_data[LEN_W-1:0];
            dfe_pkg::CSR_OCCURRENCE:    occurrence_ff    <= csr_data[OCC_W-1:0];
            default: ;
         endcase
      end
   end

   // Input handshake: hold off while the queue is full or our bank is in use
   assign req_stall  = q_full || busy_ff[bank_ff];
   assign req_accept = req_valid && !req_stall;

   // Shifted window and saturating counters for this byte
   always_comb begin
      win_step  = WIN_W'({req_text_byte, window_ff} >> dfe_pkg::BYTE_W);
      fill_step = (fill_ff < FILL_W'(MAX_PATTERN_BYTES)) ? FILL_W'(fill_ff + 1'b1) : fill_ff;
      mc_step   = (match_count_ff != '1) ? OCC_W'(match_count_ff + 1'b1) : match_count_ff;
      cap_step  = (captured_ff != '1) ? CAP_W'(captured_ff + 1'b1) : captured_ff;
      start_len = dfe_pkg::eff_len(start_length_ff, MAX_PATTERN_BYTES);
      end_len   = dfe_pkg::eff_len(end_length_ff, MAX_PATTERN_BYTES);
   end

   // Parallel delimiter compare, one candidate per length, newest byte on top
   always_comb begin
      logic s_eq;
      logic e_eq;
      start_seen = 1'b0;
      end_seen   = 1'b0;
      for (int l = 1; l <= MAX_PATTERN_BYTES; l++) begin
         s_eq = 1'b1;
         e_eq = 1'b1;
         for (int j = 0; j < l; j++) begin
            s_eq = s_eq & (win_step[dfe_pkg::BYTE_W*(MAX_PATTERN_BYTES-l+j) +: dfe_pkg::BYTE_W]
                           == start_pattern_ff[dfe_pkg::BYTE_W*j +: dfe_pkg::BYTE_W]);
            e_eq = e_eq & (win_step[dfe_pkg::BYTE_W*(MAX_PATTERN_BYTES-l+j) +: dfe_pkg::BYTE_W]
                           == end_pattern_ff[dfe_pkg::BYTE_W*j +: dfe_pkg::BYTE_W]);
         end
         if (LEN_W'(l) == start_len) begin
            start_seen = s_eq;
         end
         if (LEN_W'(l) == end_len) begin
            end_seen = e_eq;
         end
      end
   end

   // Field open/close decisions and payload sizing
   always_comb begin
      start_hit   = start_seen && (LEN_W'(fill_step) >= start_len);
      open_field  = (phase_ff == dfe_pkg::PH_SEARCH) && start_hit &&
                    (occurrence_ff != '0) && (mc_step == occurrence_ff);
      close_field = (phase_ff == dfe_pkg::PH_CAPTURE) && end_seen &&
                    (LEN_W'(fill_step) >= end_len);
      payload     = CAP_W'(cap_step - CAP_W'(end_len));
      truncated   = payload > CAP_W'(CAPTURE_DEPTH);
      run_count   = truncated ? CNT_W'(CAPTURE_DEPTH) : payload[CNT_W-1:0];
   end

   // Phase next state
   always_comb begin
      phase_in = phase_ff;
      if (req_accept) begin
         unique case (phase_ff)
            dfe_pkg::PH_SEARCH:  if (open_field) phase_in = dfe_pkg::PH_CAPTURE;
            dfe_pkg::PH_CAPTURE: if (close_field) phase_in = dfe_pkg::PH_DONE;
            dfe_pkg::PH_DONE:    phase_in = dfe_pkg::PH_DONE;
            default:             phase_in = dfe_pkg::PH_SEARCH;
         endcase
         if (req_source_end) begin
            phase_in = dfe_pkg::PH_SEARCH;
         end
      end
   end

   // Datapath, capture writes and command issue
   always_comb begin
      window_in      = window_ff;
      fill_in        = fill_ff;
      match_count_in = match_count_ff;
      captured_in    = captured_ff;
      bank_in        = bank_ff;
      busy_in        = busy_ff;
      cmd_push       = 1'b0;
      cmd_ctl.bank    = bank_ff;
      cmd_ctl.outcome = dfe_pkg::OUTCOME_NOT_FOUND;
      cmd_count      = '0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = {bank_ff, captured_ff[IDX_W-1:0]};
      ram_wr_data    = req_text_byte;

      // back end done reading a bank
      if (release_in.valid) begin
         busy_in[release_in.bank] = 1'b0;
      end

      if (req_accept) begin
         window_in = win_step;
         fill_in   = fill_step;
         if ((phase_ff == dfe_pkg::PH_SEARCH) && start_hit) begin
            match_count_in = mc_step;
         end
         if (open_field) begin
            fill_in     = '0;
            captured_in = '0;
         end
         if (phase_ff == dfe_pkg::PH_CAPTURE) begin
            ram_wr_en   = captured_ff < CAP_W'(CAPTURE_DEPTH);
            captured_in = cap_step;
         end
         if (close_field) begin
            cmd_push        = 1'b1;
            cmd_ctl.outcome = truncated ? dfe_pkg::OUTCOME_TRUNCATED : dfe_pkg::OUTCOME_FOUND;
            cmd_count       = run_count;
            // a non-empty run owns this bank until the back end drains it
            if (run_count != '0) begin
               busy_in[bank_ff] = 1'b1;
               bank_in          = !bank_ff;
            end
         end
         if (req_source_end) begin
            if (!close_field && (phase_ff != dfe_pkg::PH_DONE)) begin
               cmd_push        = 1'b1;
               cmd_ctl.outcome = dfe_pkg::OUTCOME_NOT_FOUND;
               cmd_count       = '0;
            end
            window_in      = '0;
            fill_in        = '0;
            match_count_in = '0;
            captured_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '0;
         fill_ff        <= '0;
         match_count_ff <= '0;
         phase_ff       <= dfe_pkg::PH_SEARCH;
         captured_ff    <= '0;
         bank_ff        <= 1'b0;
         busy_ff        <= '0;
      end else begin
         window_ff      <= window_in;
         fill_ff        <= fill_in;
         match_count_ff <= match_count_in;
         phase_ff       <= phase_in;
         captured_ff    <= captured_in;
         bank_ff        <= bank_in;
         busy_ff        <= busy_in;
      end
   end

   // A capture write never lands in a bank the back end still reads
   a_write_free_bank: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !busy_ff[bank_ff])
      else $error("capture write into a bank that is still draining");

   // Only one command per transfer, and never into a full queue
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (req_accept && !q_full))
      else $error("run command issued without a transfer or queue room");

endmodule

// ===== hw/rtl/dfe_back.sv =====
// ----------------------------------------------------------------------------
// dfe_back: result back end of the delimited field extractor
// Pops run commands, reads the payload from the capture RAM one byte per
// cycle while the result channel does not stall, and drives the result
// channel through a read stage and an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfe_back #(
   parameter int CAPTURE_DEPTH = dfe_pkg::CAPTURE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // command queue
   input  logic                                q_empty,
   input  dfe_pkg::cmd_ctl_type                cmd_ctl,
   input  logic [$clog2(CAPTURE_DEPTH+1)-1:0]  cmd_count,
   output logic                                cmd_pop,
   // capture RAM read port
   output logic                                ram_rd_en,
   output logic [$clog2(CAPTURE_DEPTH):0]      ram_rd_addr,
   input  logic [dfe_pkg::BYTE_W-1:0]          ram_rd_data,
   // bank hand-back to the front end
   output dfe_pkg::release_type                release_out,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dfe_pkg::BYTE_W-1:0]          rsp_field_byte,
   output logic                                rsp_byte_present,
   output logic                                rsp_run_last,
   output logic [dfe_pkg::OUTCOME_W-1:0]       rsp_outcome
);

   localparam int IDX_W = $clog2(CAPTURE_DEPTH);
   localparam int CNT_W = $clog2(CAPTURE_DEPTH + 1);

   // Run in progress
   logic                  run_active_ff, run_active_in;
   logic                  run_bank_ff, run_bank_in;
   logic [CNT_W-1:0]      run_count_ff, run_count_in;
   logic [CNT_W-1:0]      run_idx_ff, run_idx_in;
   dfe_pkg::outcome_type  run_oc_ff, run_oc_in;

   // Read stage (RAM data arrives with it)
   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_present_ff, pend_present_in;
   logic                  pend_last_ff, pend_last_in;
   dfe_pkg::outcome_type  pend_oc_ff, pend_oc_in;

   // Output register
   logic                        out_valid_ff, out_valid_in;
   logic [dfe_pkg::BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic                        out_present_ff, out_present_in;
   logic                        out_last_ff, out_last_in;
   dfe_pkg::outcome_type        out_oc_ff, out_oc_in;

   // Current element
   logic                  have_item;
   logic                  cur_bank;
   logic [CNT_W-1:0]      cur_count;
   logic [CNT_W-1:0]      cur_idx;
   dfe_pkg::outcome_type  cur_oc;
   logic                  cur_present;
   logic [CNT_W-1:0]      idx_next;
   logic                  cur_last;
   logic                  pend_adv;
   logic                  slot_free;
   logic                  issue;

   // Pick the element to issue: running run first, else the queue head
   always_comb begin
      have_item = run_active_ff || !q_empty;
      if (run_active_ff) begin
         cur_bank  = run_bank_ff;
         cur_count = run_count_ff;
         cur_idx   = run_idx_ff;
         cur_oc    = run_oc_ff;
      end else begin
         cur_bank  = cmd_ctl.bank;
         cur_count = cmd_count;
         cur_idx   = '0;
         cur_oc    = cmd_ctl.outcome;
      end
      cur_present = (cur_count != '0);
      idx_next    = CNT_W'(cur_idx + 1'b1);
      cur_last    = !cur_present || (idx_next == cur_count);
      pend_adv    = pend_valid_ff && (!out_valid_ff || !rsp_stall);
      slot_free   = !pend_valid_ff || pend_adv;
      issue       = slot_free && have_item;
   end

   assign cmd_pop           = issue && !run_active_ff;
   assign ram_rd_en         = issue && cur_present;
   assign ram_rd_addr       = {cur_bank, cur_idx[IDX_W-1:0]};
   assign release_out.valid = issue && cur_present && cur_last;
   assign release_out.bank  = cur_bank;

   // Run sequencer
   always_comb begin
      run_active_in = run_active_ff;
      run_bank_in   = run_bank_ff;
      run_count_in  = run_count_ff;
      run_idx_in    = run_idx_ff;
      run_oc_in     = run_oc_ff;
      if (issue) begin
         run_active_in = !cur_last;
         run_bank_in   = cur_bank;
         run_count_in  = cur_count;
         run_idx_in    = idx_next;
         run_oc_in     = cur_oc;
      end
   end

   // Read stage and output register
   always_comb begin
      pend_valid_in   = pend_valid_ff;
      pend_present_in = pend_present_ff;
      pend_last_in    = pend_last_ff;
      pend_oc_in      = pend_oc_ff;
      out_valid_in    = out_valid_ff;
      out_byte_in     = out_byte_ff;
      out_present_in  = out_present_ff;
      out_last_in     = out_last_ff;
      out_oc_in       = out_oc_ff;
      if (slot_free) begin
         pend_valid_in   = issue;
         pend_present_in = cur_present;
         pend_last_in    = cur_last;
         pend_oc_in      = cur_oc;
      end
      if (pend_adv) begin
         out_valid_in   = 1'b1;
         out_byte_in    = pend_present_ff ? ram_rd_data : '0;
         out_present_in = pend_present_ff;
         out_last_in    = pend_last_ff;
         out_oc_in      = pend_oc_ff;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         run_active_ff <= run_active_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_bank_ff     <= run_bank_in;
      run_count_ff    <= run_count_in;
      run_idx_ff      <= run_idx_in;
      run_oc_ff       <= run_oc_in;
      pend_present_ff <= pend_present_in;
      pend_last_ff    <= pend_last_in;
      pend_oc_ff      <= pend_oc_in;
      out_byte_ff     <= out_byte_in;
      out_present_ff  <= out_present_in;
      out_last_ff     <= out_last_in;
      out_oc_ff       <= out_oc_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_field_byte   = out_byte_ff;
   assign rsp_byte_present = out_present_ff;
   assign rsp_run_last     = out_last_ff;
   assign rsp_outcome      = out_oc_ff;

   // An empty or status-only result always closes its run
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_present_ff) |-> (out_last_ff && (out_byte_ff == '0)))
      else $error("empty result not marked as end of run");

   // Payload bytes only belong to found or truncated runs
   a_payload_found: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_present_ff) |-> (out_oc_ff != dfe_pkg::OUTCOME_NOT_FOUND))
      else $error("payload byte carries not-found outcome");

endmodule

// ===== hw/rtl/delimited_field_extractor.sv =====
// ----------------------------------------------------------------------------
// delimited_field_extractor: n-th occurrence delimited field extraction
// The byte that closes the field (or ends the source) queues a run command;
//   payload bytes then stream out 1 per cycle while rsp_stall is low.
// Throughput: 1 text byte per cycle; req_stall rises only while both capture
//   RAM banks wait to be drained or the 2-entry command queue is full.
// Reset: synchronous; clears registers to their defaults and all scan state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delimited_field_extractor #(
   parameter int CAPTURE_DEPTH     = dfe_pkg::CAPTURE_DEPTH_DEFAULT,
   parameter int MAX_PATTERN_BYTES = dfe_pkg::MAX_PATTERN_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write,
   input  logic [dfe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dfe_pkg::CSR_DATA_W-1:0]     csr_data,
   // text input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dfe_pkg::BYTE_W-1:0]         req_text_byte,
   input  logic                               req_source_end,
   // results
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [dfe_pkg::BYTE_W-1:0]         rsp_field_byte,
   output logic                               rsp_byte_present,
   output logic                               rsp_run_last,
   output logic [dfe_pkg::OUTCOME_W-1:0]      rsp_outcome
);

   localparam int CNT_W   = $clog2(CAPTURE_DEPTH + 1);
   localparam int ADDR_W  = $clog2(CAPTURE_DEPTH) + 1;
   localparam int CTL_W   = $bits(dfe_pkg::cmd_ctl_type);
   localparam int CMD_W   = CTL_W + CNT_W;

   logic                         q_full;
   logic                         q_empty;
   logic                         cmd_push;
   logic                         cmd_pop;
   dfe_pkg::cmd_ctl_type         push_ctl;
   logic [CNT_W-1:0]             push_count;
   logic [CMD_W-1:0]             pop_data;
   dfe_pkg::cmd_ctl_type         pop_ctl;
   logic [CNT_W-1:0]             pop_count;
   dfe_pkg::release_type         bank_release;
   logic                         ram_wr_en;
   logic [ADDR_W-1:0]            ram_wr_addr;
   logic [dfe_pkg::BYTE_W-1:0]   ram_wr_data;
   logic                         ram_rd_en;
   logic [ADDR_W-1:0]            ram_rd_addr;
   logic [dfe_pkg::BYTE_W-1:0]   ram_rd_data;

   // Scan front end
   dfe_front #(
      .CAPTURE_DEPTH     (CAPTURE_DEPTH),
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_source_end (req_source_end),
      .q_full         (q_full),
      .cmd_push       (cmd_push),
      .cmd_ctl        (push_ctl),
      .cmd_count      (push_count),
      .release_in     (bank_release),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data)
   );

   // Run commands between the two halves
   dfe_cmd_queue #(
      .WIDTH (CMD_W),
      .DEPTH (dfe_pkg::CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({push_ctl, push_count}),
      .pop       (cmd_pop),
      .pop_data  (pop_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign pop_ctl   = dfe_pkg::cmd_ctl_type'(pop_data[CMD_W-1:CNT_W]);
   assign pop_count = pop_data[CNT_W-1:0];

   // Two-bank capture buffer
   dfe_ram #(
      .WIDTH (dfe_pkg::BYTE_W),
      .DEPTH (2 ** ADDR_W)
   ) u_capture_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Result back end
   dfe_back #(
      .CAPTURE_DEPTH (CAPTURE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .cmd_ctl          (pop_ctl),
      .cmd_count        (pop_count),
      .cmd_pop          (cmd_pop),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .release_out      (bank_release),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_field_byte   (rsp_field_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_run_last     (rsp_run_last),
      .rsp_outcome      (rsp_outcome)
   );

endmodule

// ===== bench/dfe_field_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_field_checker: result predictor and scoreboard for the field extractor
// Watches the register port and both channels. Every text byte transfer runs
// through a local model of the delimiter scan. The field results it produces
// are queued, and each result transfer is checked field by field against the
// oldest queued entry. The mismatch count and the number of results still due
// go back to the bench top.
// ----------------------------------------------------------------------------

module dfe_field_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [dfe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dfe_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [dfe_pkg::BYTE_W-1:0]       req_text_byte,
   input  logic                             req_source_end,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [dfe_pkg::BYTE_W-1:0]       rsp_field_byte,
   input  logic                             rsp_byte_present,
   input  logic                             rsp_run_last,
   input  logic [dfe_pkg::OUTCOME_W-1:0]    rsp_outcome,
   output int                               mismatches,
   output int                               outstanding
);

   import dfe_pkg::*;

   localparam int DEPTH     = CAPTURE_DEPTH_DEFAULT;
   localparam int MAX_BYTES = MAX_PATTERN_BYTES_DEFAULT;

   typedef struct packed {
      logic [BYTE_W-1:0] field_byte;
      logic              byte_present;
      logic              run_last;
      outcome_type       outcome;
   } field_result_type;

   // register copies
   logic [PATTERN_W-1:0]    start_pat;
   logic [LENGTH_W-1:0]     start_len;
   logic [PATTERN_W-1:0]    end_pat;
   logic [LENGTH_W-1:0]     end_len;
   logic [OCC_W-1:0]        occ_sel;

   // scan state of the current source
   logic [PATTERN_W-1:0]    window;
   int unsigned             window_bytes;
   logic [OCC_W-1:0]        start_hits;
   phase_type               scan_phase;
   logic [CAPT_COUNT_W-1:0] captured;
   logic [BYTE_W-1:0]       field_buf [DEPTH];

   field_result_type expected_field_q [$];

   // length code to bytes actually compared
   function automatic int unsigned used_len(logic [LENGTH_W-1:0] code);
      if (code == '0) return 1;
      if (code > MAX_BYTES) return MAX_BYTES;
      return code;
   endfunction

   // newest bytes of the window against the low bytes of a delimiter
   function automatic logic tail_matches(logic [PATTERN_W-1:0] pat,
                                         logic [LENGTH_W-1:0] code);
      int unsigned          n;
      logic [PATTERN_W-1:0] mask;
      n = used_len(code);
      if (window_bytes < n) return 1'b0;
      mask = (n == MAX_BYTES) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      return (window >> (PATTERN_W - 8 * n)) == (pat & mask);
   endfunction

   function automatic void clear_scan();
      window       = '0;
      window_bytes = 0;
      start_hits   = '0;
      scan_phase   = PH_SEARCH;
      captured     = '0;
   endfunction

   function automatic void push_result(logic [BYTE_W-1:0] b, logic present, logic last,
                                       outcome_type oc);
      field_result_type r;
      r.field_byte   = b;
      r.byte_present = present;
      r.run_last     = last;
      r.outcome      = oc;
      expected_field_q.push_back(r);
   endfunction

   // one text byte through the scan; queues whatever results it closes
   function automatic void scan_text_byte(logic [BYTE_W-1:0] b, logic source_end);
      int unsigned payload;
      int unsigned count;
      int unsigned j;
      outcome_type oc;
      window = {b, window[PATTERN_W-1:BYTE_W]};
      if (window_bytes < MAX_BYTES) window_bytes++;
      case (scan_phase)
         PH_SEARCH: begin
            if (tail_matches(start_pat, start_len)) begin
               if (start_hits != '1) start_hits = start_hits + 1'b1;
               if (occ_sel != '0 && start_hits == occ_sel) begin
                  // window restarts so the end delimiter never overlaps the start
                  scan_phase   = PH_CAPTURE;
                  window_bytes = 0;
                  captured     = '0;
               end
            end
         end
         PH_CAPTURE: begin
            if (captured < DEPTH) field_buf[captured] = b;
            if (captured != '1) captured = captured + 1'b1;
            if (tail_matches(end_pat, end_len)) begin
               payload = captured - used_len(end_len);
               count   = payload;
               oc      = OUTCOME_FOUND;
               if (payload > DEPTH) begin
                  count = DEPTH;
                  oc    = OUTCOME_TRUNCATED;
               end
               if (count == 0) begin
                  push_result('0, 1'b0, 1'b1, oc);
               end else begin
                  for (j = 0; j < count; j++) begin
                     push_result(field_buf[j], 1'b1, (j + 1 == count), oc);
                  end
               end
               scan_phase = PH_DONE;
            end
         end
         default: ;
      endcase
      if (source_end) begin
         if (scan_phase != PH_DONE) push_result('0, 1'b0, 1'b1, OUTCOME_NOT_FOUND);
         clear_scan();
      end
   endfunction

   // everything sampled at the clock edge
   always @(posedge clock) begin : watch
      field_result_type want;
      if (reset) begin
         start_pat  = '0;
         start_len  = LENGTH_W'(1);
         end_pat    = '0;
         end_len    = LENGTH_W'(1);
         occ_sel    = OCC_W'(1);
         mismatches = 0;
         clear_scan();
         expected_field_q.delete();
      end else begin
         // register writes apply at once
         if (csr_write) begin
            case (csr_index)
               CSR_START_PATTERN: start_pat = csr_data;
               CSR_START_LENGTH:  start_len = csr_data[LENGTH_W-1:0];
               CSR_END_PATTERN:   end_pat   = csr_data;
               CSR_END_LENGTH:    end_len   = csr_data[LENGTH_W-1:0];
               CSR_OCCURRENCE:    occ_sel   = csr_data[OCC_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) scan_text_byte(req_text_byte, req_source_end);
         // result transfer against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_field_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected result: byte %02h present %0b last %0b outcome %0d",
                           $realtime, rsp_field_byte, rsp_byte_present, rsp_run_last,
                           rsp_outcome);
               end
            end else begin
               want = expected_field_q.pop_front();
               if (want.field_byte !== rsp_field_byte || want.byte_present !== rsp_byte_present
                   || want.run_last !== rsp_run_last || want.outcome !== rsp_outcome) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result mismatch: expected byte %02h present %0b last %0b %s%0d",
                              $realtime, want.field_byte, want.byte_present, want.run_last,
                              "outcome ", want.outcome);
                     $display("%0t:                  got byte %02h present %0b last %0b outcome %0d",
                              $realtime, rsp_field_byte, rsp_byte_present, rsp_run_last,
                              rsp_outcome);
                  end
               end
            end
         end
      end
      outstanding <= expected_field_q.size();
   end

endmodule

// ===== bench/tb_delimited_field_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delimited_field_extractor: stimulus and verdict for the field extractor
// Runs a few hand-built sources (reset setting, start/end overlap, overlapping
// start matches, empty field, occurrence 0), then phases of random sources
// under changing register settings, extremes included. Both channels idle at
// random. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_delimited_field_extractor;

   import dfe_pkg::*;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_write      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_text_byte  = 8'h01;
   logic                   req_source_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [BYTE_W-1:0]      rsp_field_byte;
   logic                   rsp_byte_present;
   logic                   rsp_run_last;
   logic [OUTCOME_W-1:0]   rsp_outcome;
   int                     mismatches;
   int                     outstanding;

   // current setting as the stimulus sees it (bytes used, not raw codes)
   logic [PATTERN_W-1:0]   start_delim = '0;
   int unsigned            start_used  = 1;
   logic [PATTERN_W-1:0]   end_delim   = '0;
   int unsigned            end_used    = 1;
   int unsigned            occ_now     = 1;
   logic                   steady      = 1'b0;
   int unsigned            bytes_sent  = 0;
   logic [BYTE_W-1:0]      text_q [$];

   always #2 clock = ~clock;

   delimited_field_extractor dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_source_end   (req_source_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_field_byte   (rsp_field_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_run_last     (rsp_run_last),
      .rsp_outcome      (rsp_outcome)
   );

   dfe_field_checker field_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_source_end   (req_source_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_field_byte   (rsp_field_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_run_last     (rsp_run_last),
      .rsp_outcome      (rsp_outcome),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // result side back-pressure, off during the steady stretch
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 6);
   end

   // hard stop
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
   endtask

   // with odd_codes, 1 byte goes out as code 0 and 8 bytes as a code above 8
   function automatic logic [LENGTH_W-1:0] length_code(int unsigned used, logic odd_codes);
      if (odd_codes && used == 1) return '0;
      if (odd_codes && used == 8) return LENGTH_W'($urandom_range(9, 15));
      return LENGTH_W'(used);
   endfunction

   // writes all five registers; unused upper data bits carry junk
   task automatic load_config(input logic [PATTERN_W-1:0] s_pat, input int unsigned s_used,
                              input logic [PATTERN_W-1:0] e_pat, input int unsigned e_used,
                              input logic [OCC_W-1:0] occ, input logic odd_codes);
      logic [CSR_DATA_W-LENGTH_W-1:0] junk;
      junk        = {28'($urandom), 32'($urandom)};
      start_delim = s_pat;
      start_used  = s_used;
      end_delim   = e_pat;
      end_used    = e_used;
      occ_now     = occ;
      write_reg(CSR_START_PATTERN, s_pat);
      write_reg(CSR_START_LENGTH, {junk, length_code(s_used, odd_codes)});
      write_reg(CSR_END_PATTERN, e_pat);
      write_reg(CSR_END_LENGTH, {junk, length_code(e_used, odd_codes)});
      write_reg(CSR_OCCURRENCE, {junk[CSR_DATA_W-OCC_W-1:0], occ});
      csr_write <= 1'b0;
   endtask

   // one text byte transfer, occasionally preceded by idling with req_valid low
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      if (!steady && $urandom_range(0, 99) < 4) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_source_end <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   // block idle: every result in, then room for anything still in flight
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic add_chars(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic add_delim(input logic [PATTERN_W-1:0] pat, input int unsigned n);
      for (int i = 0; i < n; i++) text_q.push_back(pat[8 * i +: 8]);
   endtask

   // mostly random bytes, some drawn from the delimiters
   task automatic add_noise(input int unsigned n);
      logic [PATTERN_W-1:0] src;
      logic [BYTE_W-1:0]    b;
      int unsigned          k;
      repeat (n) begin
         b = BYTE_W'($urandom_range(1, 255));
         if ($urandom_range(0, 99) < 15) begin
            src = $urandom_range(0, 1) ? start_delim : end_delim;
            k   = $urandom_range(0, 7);
            if (src[8 * k +: 8] != 0) b = src[8 * k +: 8];
         end
         text_q.push_back(b);
      end
   endtask

   // field bytes never end in the closing byte of the end delimiter
   task automatic add_payload(input int unsigned n);
      logic [BYTE_W-1:0] b;
      repeat (n) begin
         do b = BYTE_W'($urandom_range(1, 255));
         while (b == end_delim[8 * (end_used - 1) +: 8]);
         text_q.push_back(b);
      end
   endtask

   function automatic logic [PATTERN_W-1:0] random_delim();
      logic [PATTERN_W-1:0] d;
      for (int i = 0; i < 8; i++) d[8 * i +: 8] = BYTE_W'($urandom_range(1, 255));
      return d;
   endfunction

   initial begin
      int unsigned          phase_no;
      int unsigned          phase_start;
      int unsigned          random_start;
      int unsigned          src_no;
      int unsigned          payload_len;
      int unsigned          kind;
      int unsigned          placed;
      int unsigned          s_used;
      int unsigned          e_used;
      logic                 closed;
      logic [PATTERN_W-1:0] s_pat;
      logic [PATTERN_W-1:0] e_pat;
      logic [OCC_W-1:0]     occ;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset setting: a zero start delimiter never matches text
      add_chars("ab");
      send_text();

      // end search begins after the start delimiter; end and source end coincide
      wait_drained();
      load_config(64'h5958, 2, 64'h59, 1, 16'd1, 1'b0);
      add_chars("XYQY");
      send_text();

      // overlapping start matches, the second opens; trailing bytes ignored
      wait_drained();
      load_config(64'h4141, 2, 64'h5A, 1, 16'd2, 1'b1);
      add_chars("AAAbZAZ");
      send_text();
      // empty field
      add_chars("AAAZ");
      send_text();

      // occurrence 0 never opens a field
      wait_drained();
      load_config(64'h4141, 2, 64'h5A, 1, 16'd0, 1'b0);
      add_chars("AAZ");
      send_text();

      // random phases, each under a fresh setting
      random_start = bytes_sent;
      phase_no     = 0;
      while (phase_no < 6 || bytes_sent - random_start < 280) begin
         s_pat  = random_delim();
         e_pat  = random_delim();
         s_used = $urandom_range(1, 8);
         e_used = $urandom_range(1, 8);
         occ    = OCC_W'($urandom_range(1, 3));
         case (phase_no)
            0: begin
               s_pat  = '1;
               s_used = 8;
            end
            1: begin
               e_pat  = '1;
               e_used = 1;
            end
            2: occ = '1;
            4: occ = '0;
            5: begin
               s_pat  = '1;
               s_used = 1;
               e_pat  = '0;
            end
            default: ;
         endcase
         wait_drained();
         load_config(s_pat, s_used, e_pat, e_used, occ,
                      (phase_no == 0) || ($urandom_range(0, 1) == 1));
         steady <= (phase_no == 2 || phase_no == 3);

         phase_start = bytes_sent;
         src_no      = 0;
         while (src_no < 4 || bytes_sent - phase_start < 30) begin
            kind = $urandom_range(0, 99);
            // one full-depth field and one truncated field, always well formed
            if (src_no == 0 && phase_no == 1) begin
               payload_len = 64;
               kind        = 99;
            end else if (src_no == 0 && phase_no == 3) begin
               payload_len = $urandom_range(65, 100);
               kind        = 99;
            end else if ($urandom_range(0, 9) == 0) begin
               payload_len = $urandom_range(7, 20);
            end else begin
               payload_len = $urandom_range(0, 6);
            end

            placed = (occ_now >= 1 && occ_now <= 4) ? occ_now : $urandom_range(1, 2);
            closed = 1'b1;
            if (kind < 12) begin
               placed = placed - 1;
            end else if (kind < 24) begin
               closed = 1'b0;
            end else if (kind < 30) begin
               placed = 0;
               closed = 1'b0;
            end

            add_noise($urandom_range(0, 3));
            for (int k = 0; k < placed; k++) begin
               add_delim(start_delim, start_used);
               if (k + 1 < placed) add_noise($urandom_range(0, 2));
            end
            add_payload(payload_len);
            if (closed) add_delim(end_delim, end_used);
            // tail after the field; empty means the end delimiter closes the source
            case ($urandom_range(0, 3))
               0: ;
               1: begin
                  add_delim(start_delim, start_used);
                  add_delim(end_delim, end_used);
               end
               default: add_noise($urandom_range(1, 3));
            endcase
            if (text_q.size() == 0) add_noise(1);
            send_text();
            src_no++;
         end
         phase_no++;
      end

      wait_drained();
      if (mismatches == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== delimited_field_extractor.f =====
hw/rtl/dfe_pkg.sv
hw/rtl/dfe_ram.sv
hw/rtl/dfe_cmd_queue.sv
hw/rtl/dfe_front.sv
hw/rtl/dfe_back.sv
hw/rtl/delimited_field_extractor.sv
bench/dfe_field_checker.sv
bench/tb_delimited_field_extractor.sv
